// ===== rtl/core/bef_pkg.sv =====
// Shared constants and types for the band energy fingerprint block.
package bef_pkg;

	// Default sizes handed down from the top level.
	localparam int MAX_BANDS_DEF   = 64;
	localparam int ENERGY_BITS_DEF = 32;

	// Fixed widths of the ports.
	localparam int CFG_BITS   = 7;
	localparam int INPUT_BITS = 32;
	localparam int WORD_BITS  = 63;
	localparam int COUNT_BITS = 6;

	// Band count after reset.
	localparam logic [CFG_BITS-1:0] BAND_COUNT_RST = 7'd33;

	// Control that travels with a band through the decision stage.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} s1_ctl_t;

endpackage

// ===== rtl/core/bef_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module bef_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/bef_decide.sv =====
// Decision stage: compares band differences, gathers bits and holds the output register.
module bef_decide
	import bef_pkg::*;
#(
	parameter int MAX_BANDS   = MAX_BANDS_DEF,
	parameter int ENERGY_BITS = ENERGY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  s1_ctl_t                      ctl_s1,
	input  logic [$clog2(MAX_BANDS)-1:0] pos_s1,
	input  logic [ENERGY_BITS-1:0]       e_s1,
	input  logic [ENERGY_BITS-1:0]       pe_s1,
	input  logic [ENERGY_BITS-1:0]       rd_data,
	input  logic                         rd_vld_s1,
	input  logic                         cfg_clr,
	input  logic [COUNT_BITS-1:0]        bits_used,
	output logic                         adv,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [WORD_BITS-1:0]         fingerprint_word,
	output logic [COUNT_BITS-1:0]        bit_count
);

	localparam int AW = $clog2(MAX_BANDS);
	localparam int NB = MAX_BANDS - 1;

	logic [ENERGY_BITS-1:0] p_cur;
	logic [ENERGY_BITS-1:0] pold_q;
	logic [ENERGY_BITS:0]   lhs;
	logic [ENERGY_BITS:0]   rhs;
	logic                   gt;
	logic [NB-1:0]          acc_q;
	logic [NB-1:0]          acc_nxt;
	logic                   load;
	logic                   out_valid_q;

	// Entries never written since reset read as zero.
	assign p_cur = rd_vld_s1 ? rd_data : '0;

	// (E[b]-E[b-1]) - (P[b]-P[b-1]) > 0, rearranged to avoid signed operands.
	assign lhs = {1'b0, e_s1} + {1'b0, pold_q};
	assign rhs = {1'b0, pe_s1} + {1'b0, p_cur};
	assign gt  = lhs > rhs;

	// Merge the new decision bit into the running word.
	always_comb begin
		acc_nxt = ctl_s1.first ? '0 : acc_q;
		for (int i = 0; i < NB; i++) begin
			if (!ctl_s1.first && gt && (pos_s1 == AW'(i + 1))) begin
				acc_nxt[i] = 1'b1;
			end
		end
	end

	// The stage moves unless a finished word has nowhere to go.
	assign adv  = !ctl_s1.valid || !ctl_s1.last || !out_valid_q || out_ready;
	assign load = ctl_s1.valid && ctl_s1.last && adv;

	// Remember this band's previous-frame energy for the next band.
	always_ff @(posedge clk) begin
		if (ctl_s1.valid && adv) begin
			pold_q <= p_cur;
		end
	end

	// Bit accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cfg_clr) begin
			acc_q <= '0;
		end else if (ctl_s1.valid && adv) begin
			acc_q <= ctl_s1.last ? '0 : acc_nxt;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			fingerprint_word <= WORD_BITS'(acc_nxt);
			bit_count        <= bits_used;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/band_energy_fingerprint_bits.sv =====
// A word is registered for output as the frame's last band leaves the decision stage.
// Throughput: one band energy per cycle while no finished word is held at the output,
// with a single-read previous-frame memory and a pending write-back of each last band.
// Reset: control clears at once; the previous-frame memory reads as zero through
// per-entry valid flags, so no clearing pass is needed and bands are taken right away.
module band_energy_fingerprint_bits
	import bef_pkg::*;
#(
	parameter int MAX_BANDS   = MAX_BANDS_DEF,
	parameter int ENERGY_BITS = ENERGY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_BITS-1:0]   band_count,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [INPUT_BITS-1:0] band_energy,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_BITS-1:0]  fingerprint_word,
	output logic [COUNT_BITS-1:0] bit_count
);

	localparam int AW = $clog2(MAX_BANDS);

	logic [CFG_BITS-1:0]    band_count_q;
	logic [CFG_BITS-1:0]    n_w;
	logic [AW-1:0]          pos_q;
	logic [AW-1:0]          pos_eff;
	logic                   is_first;
	logic                   is_last;
	logic                   acc_in;
	logic                   adv;
	logic [ENERGY_BITS-1:0] e_w;
	logic [ENERGY_BITS-1:0] pe_q;
	logic                   pend_q;
	logic [AW-1:0]          pend_addr_q;
	logic [ENERGY_BITS-1:0] pend_data_q;
	logic                   step_we;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [ENERGY_BITS-1:0] wdata;
	logic [MAX_BANDS-1:0]   vld_q;
	logic                   rd_vld_s1;
	logic [ENERGY_BITS-1:0] rd_data;
	s1_ctl_t                ctl_s1;
	logic [AW-1:0]          pos_s1;
	logic [ENERGY_BITS-1:0] e_s1;
	logic [ENERGY_BITS-1:0] pe_s1;

	// Effective band count, clamped to the supported range.
	always_comb begin
		n_w = band_count_q;
		if (n_w < CFG_BITS'(2)) begin
			n_w = CFG_BITS'(2);
		end
		if (n_w > CFG_BITS'(MAX_BANDS)) begin
			n_w = CFG_BITS'(MAX_BANDS);
		end
	end

	// Position of the incoming band and its frame flags.
	assign pos_eff  = (CFG_BITS'(pos_q) >= n_w) ? '0 : pos_q;
	assign is_first = pos_eff == '0;
	assign is_last  = CFG_BITS'(pos_eff) == (n_w - CFG_BITS'(1));
	assign e_w      = ENERGY_BITS'(band_energy);

	assign cfg_ready = 1'b1;
	assign in_ready  = adv;
	assign acc_in    = in_valid && in_ready;

	// Band count register and band position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q <= BAND_COUNT_RST;
			pos_q        <= '0;
		end else if (cfg_valid) begin
			band_count_q <= band_count;
			pos_q        <= '0;
		end else if (acc_in) begin
			pos_q <= is_last ? '0 : AW'(pos_eff + AW'(1));
		end
	end

	// Previous band of this frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pe_q <= '0;
		end else if (acc_in) begin
			pe_q <= e_w;
		end
	end

	// The last band's own energy is written back in the cycle after it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= acc_in && is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && is_last) begin
			pend_addr_q <= pos_eff;
			pend_data_q <= e_w;
		end
	end

	// Write-back port: band b stores band b-1 of this frame, which is now spent.
	assign step_we = acc_in && !is_first;
	assign we      = pend_q || step_we;
	assign waddr   = pend_q ? pend_addr_q : AW'(pos_eff - AW'(1));
	assign wdata   = pend_q ? pend_data_q : pe_q;

	// Per-entry written flags give the all-zero reset image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			rd_vld_s1 <= vld_q[pos_eff];
		end
	end

	bef_ram #(
		.WIDTH(ENERGY_BITS),
		.DEPTH(MAX_BANDS)
	) u_prev_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (acc_in),
		.raddr(pos_eff),
		.rdata(rd_data)
	);

	// Decision stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= acc_in;
			ctl_s1.first <= is_first;
			ctl_s1.last  <= is_last;
		end
	end

	// Decision stage payload.
	always_ff @(posedge clk) begin
		if (acc_in) begin
			pos_s1 <= pos_eff;
			e_s1   <= e_w;
			pe_s1  <= pe_q;
		end
	end

	bef_decide #(
		.MAX_BANDS  (MAX_BANDS),
		.ENERGY_BITS(ENERGY_BITS)
	) u_decide (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl_s1          (ctl_s1),
		.pos_s1          (pos_s1),
		.e_s1            (e_s1),
		.pe_s1           (pe_s1),
		.rd_data         (rd_data),
		.rd_vld_s1       (rd_vld_s1),
		.cfg_clr         (cfg_valid),
		.bits_used       (COUNT_BITS'(n_w - CFG_BITS'(1))),
		.adv             (adv),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.fingerprint_word(fingerprint_word),
		.bit_count       (bit_count)
	);

`ifndef SYNTH
	// The delayed write-back never meets a band's own write-back.
	a_pend_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && step_we))
		else $error("pending write collides with band write-back");

	// A band never reads the entry being written in the same cycle.
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc_in && we && (waddr == pos_eff)))
		else $error("read and write hit the same entry");

	// The stored band position stays inside the frame.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		CFG_BITS'(pos_q) < n_w)
		else $error("band position beyond band count");

	// A new word appears only after a frame's last band left the decision stage.
	a_word_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl_s1.valid && ctl_s1.last))
		else $error("word offered without a finished frame");
`endif

endmodule
